### hw/rtl/mdt_pkg.sv
`default_nettype none

package mdt_pkg;

   localparam int SLOTS_DEFAULT = 8;
   localparam int TIME_W        = 32;
   localparam int SLOT_W        = 3;
   localparam int OP_W          = 3;
   localparam int MASK_W        = 8;

   localparam logic [OP_W-1:0] OP_TICK       = 3'd0;
   localparam logic [OP_W-1:0] OP_ARM_ONCE   = 3'd1;
   localparam logic [OP_W-1:0] OP_ARM_REPEAT = 3'd2;
   localparam logic [OP_W-1:0] OP_RESTART    = 3'd3;
   localparam logic [OP_W-1:0] OP_DISABLE    = 3'd4;

   typedef struct packed {
      logic [TIME_W-1:0] add_a;
      logic [TIME_W-1:0] add_b;
      logic [TIME_W-1:0] cmp_a;
      logic [TIME_W-1:0] cmp_b;
   } alu_req_type;

   typedef struct packed {
      logic [TIME_W-1:0] sum;
      logic              ge;
   } alu_rsp_type;

endpackage

`default_nettype wire

### hw/rtl/multi_slot_deadline_timer.sv
// Table of timer slots, each with a period, a wrapping 32-bit deadline, an
// enable bit and a repeat bit. Commands arrive as words on the req channel:
// tick, arm once, arm repeated, restart and disable. A tick scans every slot
// in index order and sends one rsp word per fired slot, with tlast set on the
// final one of that tick; a tick with nothing due sends nothing.
// The csr channel writes the handler mask and is always ready; write it only
// while the block is idle.
// Disable acts as the command is taken; arm then writes both memories, and restart
// reads the period and writes a new deadline if the slot was armed with a nonzero
// period. A tick uses one shared adder and comparator that serves each slot in turn,
// and the period and deadline memories give one registered read per slot.
// req_tready is high only between commands; one command is in work at a time.
// A stalled rsp receiver holds the scan: one fired slot waits in the output
// register and one more in a pending register before the scan stops.
// Reset clears all slots to disabled with no valid period and the mask to zero;
// it clears only registers, so it needs no clearing pass over the memories.
`default_nettype none

module multi_slot_deadline_timer #(
   parameter int SLOTS = mdt_pkg::SLOTS_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // operation[2:0], slot[5:3], period[37:6], now[69:38], zero fill
   input  wire logic [71:0] req_tdata,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // fired_slot[2:0], zero fill
   output logic [7:0]       rsp_tdata,
   output logic             rsp_tlast,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [7:0]  csr_data
);

   localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CW = $clog2(SLOTS + 1);
   localparam int TW = mdt_pkg::TIME_W;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_ARM    = 3'd1;
   localparam logic [2:0] ST_RST_RD = 3'd2;
   localparam logic [2:0] ST_RST_EX = 3'd3;
   localparam logic [2:0] ST_SC_RD  = 3'd4;
   localparam logic [2:0] ST_SC_EV  = 3'd5;
   localparam logic [2:0] ST_SC_END = 3'd6;

   logic [2:0]                   state_ff, state_in;
   logic [IW-1:0]                slot_ff, slot_in;
   logic                         arm_rep_ff, arm_rep_in;
   logic [TW-1:0]                per_ff, per_in;
   logic [TW-1:0]                now_ff, now_in;
   logic [SLOTS-1:0]             enabled_ff, enabled_in;
   logic [SLOTS-1:0]             repeat_ff, repeat_in;
   logic [SLOTS-1:0]             pvalid_ff, pvalid_in;
   logic [mdt_pkg::MASK_W-1:0]   mask_ff, mask_in;
   logic [CW-1:0]                cnt_ff, cnt_in;
   logic                         pend_valid_ff, pend_valid_in;
   logic [mdt_pkg::SLOT_W-1:0]   pend_slot_ff, pend_slot_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [mdt_pkg::SLOT_W-1:0]   rsp_slot_ff, rsp_slot_in;
   logic                         rsp_last_ff, rsp_last_in;

   logic [mdt_pkg::OP_W-1:0]     req_op;
   logic [mdt_pkg::SLOT_W-1:0]   req_slot;
   logic [TW-1:0]                req_period;
   logic [TW-1:0]                req_now;
   logic                         req_slot_ok;
   logic [IW-1:0]                req_idx;
   logic [IW-1:0]                cnt_idx;
   logic                         out_free;
   logic                         push;
   logic [mdt_pkg::SLOT_W-1:0]   push_slot;
   logic                         push_last;
   logic                         eligible;

   logic                         per_we, dl_we, ram_re;
   logic [IW-1:0]                ram_waddr, ram_raddr;
   logic [TW-1:0]                per_wdata, dl_wdata;
   logic [TW-1:0]                per_q, dl_q;

   mdt_pkg::alu_req_type         alu_req;
   mdt_pkg::alu_rsp_type         alu_rsp;

   assign req_op      = req_tdata[2:0];
   assign req_slot    = req_tdata[5:3];
   assign req_period  = req_tdata[37:6];
   assign req_now     = req_tdata[69:38];
   assign req_slot_ok = (32'(req_slot) < 32'(SLOTS));
   assign req_idx     = IW'(req_slot);
   assign cnt_idx     = cnt_ff[IW-1:0];
   assign out_free    = !rsp_valid_ff || rsp_tready;
   assign eligible    = enabled_ff[cnt_idx] && (32'(cnt_idx) < 32'(mdt_pkg::MASK_W))
                        && mask_ff[3'(cnt_idx)];

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, rsp_slot_ff};
   assign rsp_tlast  = rsp_last_ff;

   mdt_ram #(.WIDTH(TW), .DEPTH(SLOTS)) u_period_ram (
      .clock   (clock),
      .wr_en   (per_we),
      .wr_addr (ram_waddr),
      .wr_data (per_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (per_q)
   );

   mdt_ram #(.WIDTH(TW), .DEPTH(SLOTS)) u_deadline_ram (
      .clock   (clock),
      .wr_en   (dl_we),
      .wr_addr (ram_waddr),
      .wr_data (dl_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (dl_q)
   );

   mdt_alu u_alu (
      .alu_req (alu_req),
      .alu_rsp (alu_rsp)
   );

   always_comb begin
      alu_req.cmp_a = now_ff;
      alu_req.cmp_b = dl_q;
      alu_req.add_a = now_ff;
      alu_req.add_b = per_ff;
      unique case (state_ff)
         ST_RST_EX: begin
            alu_req.add_b = per_q;
         end
         ST_SC_EV: begin
            alu_req.add_a = dl_q;
            alu_req.add_b = per_q;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      slot_in       = slot_ff;
      arm_rep_in    = arm_rep_ff;
      per_in        = per_ff;
      now_in        = now_ff;
      enabled_in    = enabled_ff;
      repeat_in     = repeat_ff;
      pvalid_in     = pvalid_ff;
      mask_in       = csr_valid ? csr_data : mask_ff;
      cnt_in        = cnt_ff;
      pend_valid_in = pend_valid_ff;
      pend_slot_in  = pend_slot_ff;
      push          = 1'b0;
      push_slot     = pend_slot_ff;
      push_last     = 1'b0;
      per_we        = 1'b0;
      dl_we         = 1'b0;
      ram_re        = 1'b0;
      ram_waddr     = slot_ff;
      ram_raddr     = slot_ff;
      per_wdata     = per_ff;
      dl_wdata      = alu_rsp.sum;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               slot_in    = req_idx;
               per_in     = req_period;
               now_in     = req_now;
               arm_rep_in = (req_op == mdt_pkg::OP_ARM_REPEAT);
               cnt_in     = '0;
               if (req_op == mdt_pkg::OP_TICK) begin
                  state_in = ST_SC_RD;
               end else if (req_slot_ok) begin
                  case (req_op)
                     mdt_pkg::OP_ARM_ONCE, mdt_pkg::OP_ARM_REPEAT: begin
                        state_in = ST_ARM;
                     end
                     mdt_pkg::OP_RESTART: begin
                        state_in = ST_RST_RD;
                     end
                     mdt_pkg::OP_DISABLE: begin
                        enabled_in[req_idx] = 1'b0;
                     end
                     default: begin
                     end
                  endcase
               end
            end
         end
         ST_ARM: begin
            per_we              = 1'b1;
            dl_we               = 1'b1;
            enabled_in[slot_ff] = 1'b1;
            repeat_in[slot_ff]  = arm_rep_ff;
            pvalid_in[slot_ff]  = 1'b1;
            state_in            = ST_IDLE;
         end
         ST_RST_RD: begin
            ram_re   = 1'b1;
            state_in = ST_RST_EX;
         end
         ST_RST_EX: begin
            if (pvalid_ff[slot_ff] && (per_q != '0)) begin
               dl_we               = 1'b1;
               enabled_in[slot_ff] = 1'b1;
            end
            state_in = ST_IDLE;
         end
         ST_SC_RD: begin
            if (cnt_ff == CW'(SLOTS)) begin
               state_in = ST_SC_END;
            end else begin
               ram_re    = 1'b1;
               ram_raddr = cnt_idx;
               state_in  = ST_SC_EV;
            end
         end
         ST_SC_EV: begin
            ram_waddr = cnt_idx;
            if (eligible && alu_rsp.ge) begin
               if (!pend_valid_ff || out_free) begin
                  push          = pend_valid_ff;
                  dl_we         = 1'b1;
                  pend_valid_in = 1'b1;
                  pend_slot_in  = 3'(cnt_idx);
                  if (!repeat_ff[cnt_idx]) begin
                     enabled_in[cnt_idx] = 1'b0;
                  end
                  cnt_in   = cnt_ff + 1'b1;
                  state_in = ST_SC_RD;
               end
            end else begin
               cnt_in   = cnt_ff + 1'b1;
               state_in = ST_SC_RD;
            end
         end
         ST_SC_END: begin
            if (!pend_valid_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               push          = 1'b1;
               push_last     = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_valid_in = rsp_valid_ff;
      rsp_slot_in  = rsp_slot_ff;
      rsp_last_in  = rsp_last_ff;
      if (push) begin
         rsp_valid_in = 1'b1;
         rsp_slot_in  = push_slot;
         rsp_last_in  = push_last;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         enabled_ff    <= '0;
         repeat_ff     <= '0;
         pvalid_ff     <= '0;
         mask_ff       <= '0;
         cnt_ff        <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         enabled_ff    <= enabled_in;
         repeat_ff     <= repeat_in;
         pvalid_ff     <= pvalid_in;
         mask_ff       <= mask_in;
         cnt_ff        <= cnt_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      slot_ff      <= slot_in;
      arm_rep_ff   <= arm_rep_in;
      per_ff       <= per_in;
      now_ff       <= now_in;
      pend_slot_ff <= pend_slot_in;
      rsp_slot_ff  <= rsp_slot_in;
      rsp_last_ff  <= rsp_last_in;
   end

endmodule

`default_nettype wire

### hw/rtl/mdt_ram.sv
`default_nettype none

module mdt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8
) (
   input  wire logic                                    clock,
   input  wire logic                                    wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                        wr_data,
   input  wire logic                                    rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### hw/rtl/mdt_alu.sv
`default_nettype none

module mdt_alu (
   input  wire mdt_pkg::alu_req_type alu_req,
   output mdt_pkg::alu_rsp_type      alu_rsp
);

   always_comb begin
      alu_rsp.sum = alu_req.add_a + alu_req.add_b;
      alu_rsp.ge  = (alu_req.cmp_a >= alu_req.cmp_b);
   end

endmodule

`default_nettype wire
